// ===== rtl/core/wfv_pkg.sv =====
// Shared types and constants of the wall follower with visit map.
// Used by wfv_ctrl, wfv_map and the top level wall_follower_with_visit_map.
package wfv_pkg;

   // Fixed wheel commands of the forward, approach and exit phases
   localparam logic signed [7:0] FWD_SPEED      = 8'sd50;
   localparam logic signed [7:0] APPROACH_SPEED = 8'sd30;

   // Phase of the follower; the code is also the mode field of a result
   typedef enum logic [2:0] {
      PH_FORWARD  = 3'd0,
      PH_LEFT     = 3'd1,
      PH_APPROACH = 3'd2,
      PH_RIGHT    = 3'd3,
      PH_EXIT     = 3'd4
   } phase_type;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_FRONT_TH       = 3'd0,
      CSR_WALL_TH        = 3'd1,
      CSR_TURN_SPEED     = 3'd2,
      CSR_CELL_TICKS     = 3'd3,
      CSR_LEFT_TICKS     = 3'd4,
      CSR_APPROACH_TICKS = 3'd5,
      CSR_RIGHT_TICKS    = 3'd6,
      CSR_EXIT_TICKS     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [8:0] front_th;
      logic [8:0] wall_th;
      logic [6:0] turn_speed;
      logic [7:0] cell_ticks;
      logic [7:0] left_ticks;
      logic [7:0] approach_ticks;
      logic [7:0] right_ticks;
      logic [7:0] exit_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      front_th:       9'd10,
      wall_th:        9'd25,
      turn_speed:     7'd34,
      cell_ticks:     8'd50,
      left_ticks:     8'd97,
      approach_ticks: 8'd160,
      right_ticks:    8'd148,
      exit_ticks:     8'd180
   };

   // Command of one tick, everything but the visit count
   typedef struct packed {
      logic              step;
      phase_type         mode;
      logic [5:0]        pos_y;
      logic [5:0]        pos_x;
      logic [1:0]        heading;
      logic              ramped;
      logic signed [7:0] right_speed;
      logic signed [7:0] left_speed;
   } cmd_type;

   // Visit map controls from the pipeline
   typedef struct packed {
      logic issue;   // stepping item enters the map stage: read its cell
      logic retire;  // map stage item moves to the result register
      logic step;    // map stage item stepped into a new cell
   } map_ctrl_type;

endpackage

// ===== rtl/core/wfv_ctrl.sv =====
// Phase sequencer, tick counters, heading and position of the wall follower.
// Depends on wfv_pkg; feeds the map stage with a command and a cell address.
module wfv_ctrl #(
   parameter int GRID_SIZE = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wfv_pkg::cfg_type                      cfg,
   input  logic                                  enable,
   input  logic [8:0]                            front_cm,
   input  logic [8:0]                            right_cm,
   output wfv_pkg::cmd_type                      cmd,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] step_addr
);
   import wfv_pkg::*;

   localparam int CW     = $clog2(GRID_SIZE);
   localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

   phase_type         phase_ff, phase_in;
   logic [7:0]        phase_count_ff, phase_count_in;
   logic [7:0]        cell_count_ff, cell_count_in;
   logic [1:0]        heading_ff, heading_in;
   logic [CW-1:0]     x_ff, x_in;
   logic [CW-1:0]     y_ff, y_in;
   logic              wall;
   logic              path_clear;
   phase_type         cur_phase;
   logic [7:0]        count_base;
   logic [7:0]        count_inc;
   logic [7:0]        length;
   logic [7:0]        ts_pos;
   logic [7:0]        ts_neg;
   logic [15:0]       x_wide;
   logic [15:0]       y_wide;

   // Hold the sequencer state; advance once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FORWARD;
         phase_count_ff <= '0;
         cell_count_ff  <= '0;
         heading_ff     <= '0;
         x_ff           <= '0;
         y_ff           <= '0;
      end else if (enable) begin
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         cell_count_ff  <= cell_count_in;
         heading_ff     <= heading_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
      end
   end

   assign wall       = right_cm < cfg.wall_th;
   assign path_clear = front_cm >= cfg.front_th;
   assign ts_pos     = {1'b0, cfg.turn_speed};
   assign ts_neg     = ~ts_pos + 8'd1;

   // Next state and command of this tick
   always_comb begin
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      cell_count_in  = cell_count_ff;
      heading_in     = heading_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      cur_phase      = phase_ff;
      length         = cfg.exit_ticks;
      cmd            = '0;

      // Forward: drive along the wall or pick the phase that leaves it
      if (phase_ff == PH_FORWARD) begin
         if (path_clear && wall) begin
            cmd.left_speed  = FWD_SPEED;
            cmd.right_speed = FWD_SPEED;
            cmd.ramped      = 1'b1;
            if (cell_count_ff >= cfg.cell_ticks) begin
               cmd.step      = 1'b1;
               cell_count_in = '0;
            end else begin
               cell_count_in = cell_count_ff + 8'd1;
            end
         end else begin
            cell_count_in = '0;
            cur_phase     = wall ? PH_LEFT : PH_APPROACH;
         end
      end

      count_base = (phase_ff == PH_FORWARD) ? 8'd0 : phase_count_ff;
      count_inc  = count_base + 8'd1;

      // Timed phases: command, duration and successor
      unique case (cur_phase)
         PH_FORWARD: begin
         end
         PH_LEFT: begin
            cmd.left_speed  = ts_neg;
            cmd.right_speed = ts_pos;
            length          = cfg.left_ticks;
         end
         PH_APPROACH: begin
            cmd.left_speed  = APPROACH_SPEED;
            cmd.right_speed = APPROACH_SPEED;
            cmd.ramped      = 1'b1;
            length          = cfg.approach_ticks;
         end
         PH_RIGHT: begin
            cmd.left_speed  = ts_pos;
            cmd.right_speed = ts_neg;
            length          = cfg.right_ticks;
         end
         default: begin
            cmd.left_speed  = FWD_SPEED;
            cmd.right_speed = FWD_SPEED;
            length          = cfg.exit_ticks;
         end
      endcase

      if (cur_phase != PH_FORWARD) begin
         phase_count_in = count_inc;
         phase_in       = cur_phase;
         if (count_inc >= length) begin
            phase_count_in = '0;
            unique case (cur_phase)
               PH_LEFT: begin
                  heading_in = heading_ff - 2'd1;
                  phase_in   = PH_FORWARD;
               end
               PH_APPROACH: phase_in = PH_RIGHT;
               PH_RIGHT:    phase_in = PH_EXIT;
               default: begin
                  heading_in = heading_ff + 2'd1;
                  phase_in   = PH_FORWARD;
               end
            endcase
         end
      end

      // Step one cell along the heading, wrapping at the grid edge
      if (cmd.step) begin
         case (heading_ff)
            2'd0: y_in = (y_ff == CW'(GRID_SIZE - 1)) ? '0 : y_ff + CW'(1);
            2'd1: x_in = (x_ff == CW'(GRID_SIZE - 1)) ? '0 : x_ff + CW'(1);
            2'd2: y_in = (y_ff == '0) ? CW'(GRID_SIZE - 1) : y_ff - CW'(1);
            default: x_in = (x_ff == '0) ? CW'(GRID_SIZE - 1) : x_ff - CW'(1);
         endcase
      end

      x_wide      = 16'(x_in);
      y_wide      = 16'(y_in);
      cmd.mode    = cur_phase;
      cmd.heading = heading_in;
      cmd.pos_x   = x_wide[5:0];
      cmd.pos_y   = y_wide[5:0];
   end

   assign step_addr = ADDR_W'(x_in) * ADDR_W'(GRID_SIZE) + ADDR_W'(y_in);

endmodule

// ===== rtl/core/wfv_map.sv =====
// Visit map memory with read-modify-write of the stepped cell and the
// current cell's count. Depends on wfv_pkg; clears the memory after reset.
module wfv_map #(
   parameter int GRID_SIZE   = 64,
   parameter int COUNT_WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wfv_pkg::map_ctrl_type                 ctrl,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] rd_addr,
   output logic [COUNT_WIDTH-1:0]                visits,
   output logic                                  clearing
);
   import wfv_pkg::*;

   localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   bypass_ff;
   logic [COUNT_WIDTH-1:0] bypass_data_ff;
   logic [ADDR_W-1:0]      cell_addr_ff;
   logic [COUNT_WIDTH-1:0] cur_visits_ff;
   logic                   clearing_ff;
   logic [ADDR_W-1:0]      clear_addr_ff;
   logic [COUNT_WIDTH-1:0] old_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   hit;

   // Saturating bump of the stepped cell
   assign old_count = bypass_ff ? bypass_data_ff : rd_data_ff;
   assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_WIDTH'(1);
   assign visits    = ctrl.step ? new_count : cur_visits_ff;

   // Write back when a stepping item retires, or zero during the clearing pass
   assign wr_en   = clearing_ff || (ctrl.retire && ctrl.step);
   assign wr_addr = clearing_ff ? clear_addr_ff : cell_addr_ff;
   assign wr_data = clearing_ff ? '0 : new_count;
   assign hit     = ctrl.retire && ctrl.step && (cell_addr_ff == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.issue) begin
         rd_data_ff     <= mem[rd_addr];
         bypass_ff      <= hit;
         bypass_data_ff <= new_count;
         cell_addr_ff   <= rd_addr;
      end
   end

   // Track the current cell's count and sweep the memory after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_visits_ff <= '0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         if (ctrl.retire) begin
            cur_visits_ff <= visits;
         end
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   assign clearing = clearing_ff;

endmodule

// ===== rtl/core/wall_follower_with_visit_map.sv =====
// Right-hand wall follower with a visit map. Each req item carries one tick's
// front and right distances; each item gives exactly one rsp item with the
// wheel command, heading, cell position, visit count and phase. Items pass
// through three registers (input, map stage, result) in that order, and one
// item is taken every cycle while rsp_tready keeps up. The map stage reads
// the stepped cell from the visit memory, bumps the count and writes it back
// as the item leaves. After reset the visit memory is swept to zero, one cell
// a cycle, all GRID_SIZE*GRID_SIZE cells (4096 by default), with req_tready
// low; the csr port is always ready. The user must write it only while no
// item is in flight; the block itself has no check for this.
module wall_follower_with_visit_map #(
   parameter int GRID_SIZE   = 64,
   parameter int COUNT_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // front_cm[8:0], right_cm[17:9], zero pad
   // item out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left_speed[7:0], right_speed[15:8], ramped[16], heading[18:17],
   // pos_x[24:19], pos_y[30:25], visits[38:31], zero pad
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // mode[2:0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import wfv_pkg::*;

   localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic [8:0]            front_ff;
   logic [8:0]            right_ff;
   logic                  s2_valid_ff;
   cmd_type               s2_cmd_ff;
   logic                  rsp_valid_ff;
   logic [39:0]           rsp_data_ff;
   logic [2:0]            rsp_user_ff;
   cmd_type               cmd;
   logic [ADDR_W-1:0]     step_addr;
   map_ctrl_type          map_ctrl;
   logic [COUNT_WIDTH-1:0] visits;
   logic [15:0]           visits_wide;
   logic                  clearing;
   logic                  rsp_load;
   logic                  s2_load;
   logic                  req_accept;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRONT_TH:       cfg_ff.front_th       <= csr_data;
            CSR_WALL_TH:        cfg_ff.wall_th        <= csr_data;
            CSR_TURN_SPEED:     cfg_ff.turn_speed     <= csr_data[6:0];
            CSR_CELL_TICKS:     cfg_ff.cell_ticks     <= csr_data[7:0];
            CSR_LEFT_TICKS:     cfg_ff.left_ticks     <= csr_data[7:0];
            CSR_APPROACH_TICKS: cfg_ff.approach_ticks <= csr_data[7:0];
            CSR_RIGHT_TICKS:    cfg_ff.right_ticks    <= csr_data[7:0];
            CSR_EXIT_TICKS:     cfg_ff.exit_ticks     <= csr_data[7:0];
         endcase
      end
   end

   // Pipeline flow: each stage moves when the next one is empty or moving
   assign rsp_load   = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s2_load    = in_valid_ff && (!s2_valid_ff || rsp_load);
   assign req_tready = !clearing && (!in_valid_ff || s2_load);
   assign req_accept = req_tvalid && req_tready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (s2_load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         front_ff <= req_tdata[8:0];
         right_ff <= req_tdata[17:9];
      end
   end

   wfv_ctrl #(
      .GRID_SIZE (GRID_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .enable    (s2_load),
      .front_cm  (front_ff),
      .right_cm  (right_ff),
      .cmd       (cmd),
      .step_addr (step_addr)
   );

   // Map stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_load) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_cmd_ff <= cmd;
      end
   end

   assign map_ctrl.issue  = s2_load && cmd.step;
   assign map_ctrl.retire = rsp_load;
   assign map_ctrl.step   = s2_cmd_ff.step;

   wfv_map #(
      .GRID_SIZE   (GRID_SIZE),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (map_ctrl),
      .rd_addr  (step_addr),
      .visits   (visits),
      .clearing (clearing)
   );

   assign visits_wide = 16'(visits);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, visits_wide[7:0], s2_cmd_ff.pos_y, s2_cmd_ff.pos_x,
                         s2_cmd_ff.heading, s2_cmd_ff.ramped,
                         s2_cmd_ff.right_speed, s2_cmd_ff.left_speed};
         rsp_user_ff <= s2_cmd_ff.mode;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
